@@ rtl/e2g_pkg.sv @@
// Shared types, constants and the arctangent table of the ECEF to geodetic core.
package e2g_pkg;

  // Internal word width and fixed constants of the WGS84 conversion.
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned NSTEP = 48;
  localparam int unsigned STEP_BITS = 6;
  localparam logic [63:0] HALF_IN = 64'd1 << 46;
  localparam logic [63:0] QUARTER_IN = 64'd1 << 44;
  localparam logic [63:0] A_UM = 64'd6378137000000;
  localparam logic [63:0] E2_Q40 = 64'd7360548640;
  localparam logic [63:0] INVK_Q32 = 64'h0000_0000_9B74_EDA8;
  localparam logic [63:0] INVPI_Q64 = 64'h517C_C1B7_2722_0A95;
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
  localparam logic [63:0] HALF_MM = 64'd500;

  // Reciprocal of 1000 in Q57, rounded up; exact floor division for values below 2^50.
  localparam logic [63:0] RCP_1000_Q57 = 64'd144115188075856;

  // Last step indexes of the shared multiplier, divider and square root.
  localparam logic [6:0] DIV_LAST = 7'd63;
  localparam logic [6:0] FRAC_LAST = 7'd93;
  localparam logic [6:0] SQRT_LAST = 7'd31;
  localparam logic [6:0] MUL_LAST = 7'd4;

  // Register indexes of the configuration port.
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_ITER_LIMIT = 1'b1;

  // Operations of the shared arithmetic unit.
  typedef enum logic [2:0] {
    OP_MUL30,
    OP_MUL32,
    OP_MUL40,
    OP_MUL57,
    OP_DIV,
    OP_FRAC,
    OP_SQRT
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  // Sequencer states of the top level.
  typedef enum logic [5:0] {
    ST_IDLE,
    ST_LON_GO, ST_LON_WAIT,
    ST_PMUL_GO, ST_PMUL_WAIT,
    ST_CHECK,
    ST_ZC_GO, ST_ZC_WAIT,
    ST_HYP_GO, ST_HYP_WAIT,
    ST_FRAC_GO, ST_FRAC_WAIT,
    ST_S2_GO, ST_S2_WAIT,
    ST_EW_GO, ST_EW_WAIT,
    ST_SQ_GO, ST_SQ_WAIT,
    ST_RCP_GO, ST_RCP_WAIT,
    ST_V_GO, ST_V_WAIT,
    ST_T_GO, ST_T_WAIT,
    ST_CORR_GO, ST_CORR_WAIT,
    ST_FIN_GO, ST_FIN_WAIT,
    ST_HF_GO, ST_HF_WAIT,
    ST_RND_GO, ST_RND_WAIT,
    ST_OUT
  } state_t;

  typedef logic [63:0] atan_tab_t [NSTEP];

  // Arctangent of 2^-i with half turn = 2^46, built at elaboration from the
  // alternating series and a multiplication by 1/pi.
  function automatic atan_tab_t build_atan();
    atan_tab_t    t;
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [127:0] prod;
    int           i;
    int           k;
    int           e;
    t[0] = QUARTER_IN;
    for (i = 1; i < NSTEP; i++) begin
      sum = 64'd0;
      for (k = 0; k < 32; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          term = (64'd1 << e) / 64'(2 * k + 1);
          if (k % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      prod = {64'd0, sum} * {64'd0, INVPI_Q64};
      t[i] = {16'd0, prod[127:80]};
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = build_atan();

endpackage

@@ rtl/e2g_cordic.sv @@
// Iterative vectoring CORDIC, one micro-rotation per cycle over 48 steps.
module e2g_cordic (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x_in,
  input  logic [63:0] y_in,
  output logic [63:0] x_out,
  output logic [63:0] ang_out,
  output logic        done
);
  import e2g_pkg::*;

  logic                 busy;
  logic [STEP_BITS-1:0] step;
  logic [63:0]          xr;
  logic [63:0]          yr;
  logic [63:0]          ar;
  logic [63:0]          dx;
  logic [63:0]          dy;
  logic                 last;

  // Shifted copies for the current micro-rotation.
  assign dx = $signed(yr) >>> step;
  assign dy = $signed(xr) >>> step;
  assign last = (step == STEP_BITS'(NSTEP - 1));

  // Control: run through NSTEP micro-rotation steps after a start.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: rotate toward the x axis, accumulate the angle.
  always_ff @(posedge clk) begin
    if (start) begin
      xr <= x_in;
      yr <= y_in;
      ar <= '0;
    end else if (busy) begin
      if (!yr[63]) begin
        xr <= xr + dx;
        yr <= yr - dy;
        ar <= ar + ATAN_TAB[step];
      end else begin
        xr <= xr - dx;
        yr <= yr + dy;
        ar <= ar - ATAN_TAB[step];
      end
    end
  end

  assign x_out = xr;
  assign ang_out = ar;

endmodule

@@ rtl/e2g_arith.sv @@
// Shared multi-cycle unit: 64x64 multiply with scaling, long division, square root.
module e2g_arith (
  input  logic                   clk,
  input  logic                   rst,
  input  e2g_pkg::arith_req_t    req,
  input  logic [63:0]            a,
  input  logic [63:0]            b,
  output logic [63:0]            res,
  output logic                   done
);
  import e2g_pkg::*;

  arith_op_t    op;
  logic         busy;
  logic [6:0]   cnt;
  logic [6:0]   last;
  logic [63:0]  ra;
  logic [63:0]  rb;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic         pp_vld;
  logic [63:0]  rem;
  logic [63:0]  dsh;
  logic [63:0]  quo;
  logic         is_mul;
  logic [31:0]  ha;
  logic [31:0]  hb;
  logic [1:0]   hsh;
  logic [64:0]  dr;
  logic         dge;
  logic [65:0]  sr;
  logic [65:0]  strial;
  logic         sge;

  assign is_mul = (op == OP_MUL30) || (op == OP_MUL32) || (op == OP_MUL40) ||
                  (op == OP_MUL57);

  // Half-word selection for the four partial products.
  always_comb begin
    case (cnt[1:0])
      2'd0: begin ha = ra[31:0];  hb = rb[31:0];  hsh = 2'd0; end
      2'd1: begin ha = ra[31:0];  hb = rb[63:32]; hsh = 2'd1; end
      2'd2: begin ha = ra[63:32]; hb = rb[31:0];  hsh = 2'd1; end
      default: begin ha = ra[63:32]; hb = rb[63:32]; hsh = 2'd2; end
    endcase
  end

  // One restoring divide step and one square-root digit step.
  assign dr = {rem, dsh[63]};
  assign dge = (dr >= {1'b0, rb});
  assign sr = {rem, dsh[63:62]};
  assign strial = {quo, 2'b01};
  assign sge = (sr >= strial);

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
      pp_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
        pp_vld <= 1'b0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        pp_vld <= is_mul && (cnt < MUL_LAST);
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      op <= req.op;
      ra <= a;
      rb <= b;
      acc <= '0;
      rem <= '0;
      dsh <= a;
      quo <= '0;
      case (req.op)
        OP_DIV:  last <= DIV_LAST;
        OP_FRAC: last <= FRAC_LAST;
        OP_SQRT: last <= SQRT_LAST;
        default: last <= MUL_LAST;
      endcase
    end else if (busy) begin
      if (is_mul) begin
        if (cnt < MUL_LAST) begin
          pp <= ha * hb;
          pp_sh <= hsh;
        end
        if (pp_vld) begin
          acc <= acc + ({64'd0, pp} << {pp_sh, 5'd0});
        end
      end else if (op == OP_SQRT) begin
        rem <= sge ? 64'(sr - strial) : sr[63:0];
        quo <= {quo[62:0], sge};
        dsh <= {dsh[61:0], 2'b00};
      end else begin
        rem <= dge ? 64'(dr - {1'b0, rb}) : dr[63:0];
        quo <= {quo[62:0], dge};
        dsh <= {dsh[62:0], 1'b0};
      end
    end
  end

  // Result selection.
  always_comb begin
    case (op)
      OP_MUL30: res = acc[93:30];
      OP_MUL32: res = acc[95:32];
      OP_MUL40: res = acc[103:40];
      OP_MUL57: res = acc[120:57];
      default:  res = quo;
    endcase
  end

endmodule

@@ rtl/ecef_to_geodetic_core.sv @@
// Top level of the ECEF to WGS84 geodetic converter: sequencer, registers, ports.
//
// Usage: one position transaction (x, y, z in millimetres) enters on the s_ side
// and one result transaction (latitude, longitude, height, converged flag) leaves
// on the m_ side. Two configuration registers sit on the APB port: the tolerance
// in micrometres at byte address 0 and the iteration limit at address 4; write
// them only while the block is idle.
// Timing: one position at a time. A conversion does at most the iteration limit
// of refinements. Each refinement is one 48-step CORDIC pass plus a chain of runs
// of the shared arithmetic unit: multiplies, a 94-step fraction divide, a 32-step
// square root and a 64-step reciprocal divide. The final pass adds a CORDIC run,
// a gain-correction multiply and a multiply by the reciprocal of 1000 for rounding
// to millimetres.
// s_tready is high only while the sequencer is idle. A finished result sits in
// the output register; if m_tready is low, the next position is still taken and
// converted, and its result waits in the last sequencer state until the output
// register frees.
// Reset: synchronous, clears the sequencer and the output valid, and restores
// tolerance 100 um and iteration limit 10.
module ecef_to_geodetic_core #(
  parameter int COORD_BITS = 36,
  parameter int ANGLE_BITS = 32
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           s_tvalid,
  output logic                                           s_tready,
  // pos_x, pos_y, pos_z from the lowest bit up
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]              s_tdata,
  output logic                                           m_tvalid,
  input  logic                                           m_tready,
  // latitude, longitude, height_mm from the lowest bit up
  output logic [((2*ANGLE_BITS+COORD_BITS+7)/8)*8-1:0]   m_tdata,
  // converged
  output logic                                           m_tuser,
  input  logic                                           psel,
  input  logic                                           penable,
  input  logic                                           pwrite,
  input  logic [2:0]                                     paddr,
  input  logic [31:0]                                    pwdata,
  output logic [31:0]                                    prdata,
  output logic                                           pready
);
  import e2g_pkg::*;

  localparam int OUT_W = ((2*ANGLE_BITS+COORD_BITS+7)/8)*8;
  localparam int SH = 47 - ANGLE_BITS;
  localparam logic [63:0] ANG_RND = 64'd1 << (SH - 1);
  localparam logic signed [63:0] HMAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] HMIN = -(64'sd1 <<< (COORD_BITS - 1));

  state_t      state;
  state_t      state_next;
  logic [15:0] tolerance_um;
  logic [4:0]  iteration_limit;
  logic        cfg_wr;

  logic [63:0] z0;
  logic [63:0] p;
  logic [63:0] zc;
  logic [63:0] zk;
  logic [63:0] v;
  logic [63:0] s;
  logic [63:0] tmp;
  logic [63:0] lon_ang;
  logic [63:0] lat_ang;
  logic [4:0]  iter;
  logic        polar;
  logic        lon_neg;
  logic        zneg;
  logic        conv;
  logic        hneg;

  logic [63:0] xs;
  logic [63:0] ys;
  logic [63:0] zs;
  logic [63:0] xm;
  logic [63:0] ym;
  logic [63:0] zm;
  logic [63:0] dz;
  logic [63:0] adz;
  logic        tol_met;
  logic        iter_done;
  logic [63:0] az;
  logic [63:0] hraw;
  logic [63:0] hv;
  logic [COORD_BITS-1:0] h_out;
  logic [63:0] lat_sum;
  logic [63:0] lon_sum;
  logic        out_free;

  logic        c_start;
  logic [63:0] c_x;
  logic [63:0] c_ang;
  logic        c_done;
  arith_req_t  a_req;
  logic [63:0] a_a;
  logic [63:0] a_b;
  logic [63:0] a_res;
  logic        a_done;

  // Shared units.
  e2g_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (c_start),
    .x_in    (p),
    .y_in    (zc),
    .x_out   (c_x),
    .ang_out (c_ang),
    .done    (c_done)
  );

  e2g_arith u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (a_req),
    .a    (a_a),
    .b    (a_b),
    .res  (a_res),
    .done (a_done)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_TOLERANCE:  prdata = {16'd0, tolerance_um};
      REG_ITER_LIMIT: prdata = {27'd0, iteration_limit};
      default:        prdata = '0;
    endcase
  end

  // Input scaling to micrometres: x * 1000 = x*1024 - x*16 - x*8.
  assign xs = {{(64-COORD_BITS){s_tdata[COORD_BITS-1]}}, s_tdata[COORD_BITS-1:0]};
  assign ys = {{(64-COORD_BITS){s_tdata[2*COORD_BITS-1]}},
               s_tdata[2*COORD_BITS-1:COORD_BITS]};
  assign zs = {{(64-COORD_BITS){s_tdata[3*COORD_BITS-1]}},
               s_tdata[3*COORD_BITS-1:2*COORD_BITS]};
  assign xm = (xs << 10) - (xs << 4) - (xs << 3);
  assign ym = (ys << 10) - (ys << 4) - (ys << 3);
  assign zm = (zs << 10) - (zs << 4) - (zs << 3);

  // Convergence test and helpers.
  assign dz = zc - zk;
  assign adz = dz[63] ? -dz : dz;
  assign tol_met = (adz < {48'd0, tolerance_um});
  assign iter_done = (iter >= iteration_limit);
  assign az = zneg ? -zc : zc;
  assign hraw = a_res - v;
  assign hv = hneg ? -tmp : tmp;
  assign out_free = !m_tvalid || m_tready;
  assign lat_sum = lat_ang + ANG_RND;
  assign lon_sum = lon_ang + ANG_RND;

  // Height saturation to the output range.
  always_comb begin
    if ($signed(hv) > HMAX) begin
      h_out = HMAX[COORD_BITS-1:0];
    end else if ($signed(hv) < HMIN) begin
      h_out = HMIN[COORD_BITS-1:0];
    end else begin
      h_out = hv[COORD_BITS-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_LON_GO;
      ST_LON_GO:    state_next = ST_LON_WAIT;
      ST_LON_WAIT:  if (c_done) state_next = ST_PMUL_GO;
      ST_PMUL_GO:   state_next = ST_PMUL_WAIT;
      ST_PMUL_WAIT: if (a_done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (tol_met || iter_done) begin
          state_next = ST_FIN_GO;
        end else begin
          state_next = ST_ZC_GO;
        end
      end
      ST_ZC_GO:     state_next = ST_ZC_WAIT;
      ST_ZC_WAIT:   if (c_done) state_next = ST_HYP_GO;
      ST_HYP_GO:    state_next = ST_HYP_WAIT;
      ST_HYP_WAIT:  if (a_done) state_next = ST_FRAC_GO;
      ST_FRAC_GO:   state_next = ST_FRAC_WAIT;
      ST_FRAC_WAIT: if (a_done) state_next = ST_S2_GO;
      ST_S2_GO:     state_next = ST_S2_WAIT;
      ST_S2_WAIT:   if (a_done) state_next = ST_EW_GO;
      ST_EW_GO:     state_next = ST_EW_WAIT;
      ST_EW_WAIT:   if (a_done) state_next = ST_SQ_GO;
      ST_SQ_GO:     state_next = ST_SQ_WAIT;
      ST_SQ_WAIT:   if (a_done) state_next = ST_RCP_GO;
      ST_RCP_GO:    state_next = ST_RCP_WAIT;
      ST_RCP_WAIT:  if (a_done) state_next = ST_V_GO;
      ST_V_GO:      state_next = ST_V_WAIT;
      ST_V_WAIT:    if (a_done) state_next = ST_T_GO;
      ST_T_GO:      state_next = ST_T_WAIT;
      ST_T_WAIT:    if (a_done) state_next = ST_CORR_GO;
      ST_CORR_GO:   state_next = ST_CORR_WAIT;
      ST_CORR_WAIT: if (a_done) state_next = ST_CHECK;
      ST_FIN_GO:    state_next = ST_FIN_WAIT;
      ST_FIN_WAIT:  if (c_done) state_next = ST_HF_GO;
      ST_HF_GO:     state_next = ST_HF_WAIT;
      ST_HF_WAIT:   if (a_done) state_next = ST_RND_GO;
      ST_RND_GO:    state_next = ST_RND_WAIT;
      ST_RND_WAIT:  if (a_done) state_next = ST_OUT;
      ST_OUT:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: unit starts and operand selection.
  always_comb begin
    s_tready = (state == ST_IDLE);
    c_start = (state == ST_LON_GO) || (state == ST_ZC_GO) || (state == ST_FIN_GO);
    a_req.start = 1'b0;
    a_req.op = OP_MUL30;
    a_a = tmp;
    a_b = s;
    case (state)
      ST_PMUL_GO, ST_HYP_GO, ST_HF_GO: begin
        a_req.start = 1'b1;
        a_req.op = OP_MUL32;
        a_a = c_x;
        a_b = INVK_Q32;
      end
      ST_FRAC_GO: begin
        a_req.start = 1'b1;
        a_req.op = OP_FRAC;
        a_a = (az < tmp) ? az : tmp;
        a_b = tmp;
      end
      ST_S2_GO: begin
        a_req.start = 1'b1;
        a_a = s;
      end
      ST_EW_GO: begin
        a_req.start = 1'b1;
        a_req.op = OP_MUL40;
        a_a = E2_Q40;
        a_b = tmp;
      end
      ST_SQ_GO: begin
        a_req.start = 1'b1;
        a_req.op = OP_SQRT;
        a_a = tmp << 30;
      end
      ST_RCP_GO: begin
        a_req.start = 1'b1;
        a_req.op = OP_DIV;
        a_a = ONE_Q60;
        a_b = tmp;
      end
      ST_V_GO: begin
        a_req.start = 1'b1;
        a_a = A_UM;
        a_b = tmp;
      end
      ST_T_GO: begin
        a_req.start = 1'b1;
        a_req.op = OP_MUL40;
        a_a = v;
        a_b = E2_Q40;
      end
      ST_CORR_GO: begin
        a_req.start = 1'b1;
      end
      // Division by 1000 as a multiplication by its scaled reciprocal.
      ST_RND_GO: begin
        a_req.start = 1'b1;
        a_req.op = OP_MUL57;
        a_b = RCP_1000_Q57;
      end
      default: begin
        a_req.start = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      tolerance_um <= 16'd100;
      iteration_limit <= 5'd10;
    end else begin
      state <= state_next;
      if (cfg_wr) begin
        case (paddr[2])
          REG_TOLERANCE:  tolerance_um <= pwdata[15:0];
          REG_ITER_LIMIT: iteration_limit <= pwdata[4:0];
          default:        tolerance_um <= tolerance_um;
        endcase
      end
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Working registers of the conversion.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          z0 <= zm;
          polar <= (xm == 64'd0) && (ym == 64'd0);
          lon_neg <= xm[63];
          p <= xm[63] ? -xm : xm;
          zc <= xm[63] ? -ym : ym;
        end
      end
      ST_LON_WAIT: begin
        if (c_done) lon_ang <= c_ang + (lon_neg ? HALF_IN : 64'd0);
      end
      ST_PMUL_WAIT: begin
        if (a_done) begin
          p <= a_res;
          zc <= z0;
          zk <= '0;
          v <= A_UM;
          iter <= '0;
        end
      end
      ST_CHECK: begin
        conv <= tol_met;
        if (!tol_met && !iter_done) begin
          zk <= zc;
          zneg <= zc[63];
        end
      end
      ST_HYP_WAIT, ST_S2_WAIT, ST_RCP_WAIT, ST_T_WAIT, ST_RND_WAIT: begin
        if (a_done) tmp <= a_res;
      end
      ST_FRAC_WAIT: begin
        if (a_done) s <= (tmp == 64'd0) ? 64'd0 : a_res;
      end
      ST_EW_WAIT: begin
        if (a_done) tmp <= ONE_Q30 - a_res;
      end
      ST_SQ_WAIT: begin
        if (a_done) tmp <= (a_res == 64'd0) ? 64'd1 : a_res;
      end
      ST_V_WAIT: begin
        if (a_done) v <= a_res;
      end
      ST_CORR_WAIT: begin
        if (a_done) begin
          zc <= zneg ? z0 - a_res : z0 + a_res;
          iter <= iter + 1'b1;
        end
      end
      ST_FIN_WAIT: begin
        if (c_done) begin
          if (polar) begin
            lat_ang <= $signed(z0) > 64'sd0 ? QUARTER_IN : -QUARTER_IN;
            lon_ang <= '0;
          end else begin
            lat_ang <= c_ang;
          end
        end
      end
      ST_HF_WAIT: begin
        if (a_done) begin
          hneg <= hraw[63];
          tmp <= (hraw[63] ? -hraw : hraw) + HALF_MM;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata <= OUT_W'({h_out, lon_sum[SH +: ANGLE_BITS], lat_sum[SH +: ANGLE_BITS]});
          m_tuser <= conv;
        end
      end
      default: begin
        tmp <= tmp;
      end
    endcase
  end

  // The two shared units never finish in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(c_done && a_done))
    else $error("CORDIC and arithmetic unit finished together");

  // A CORDIC result only arrives while the sequencer waits for one.
  assert property (@(posedge clk) disable iff (rst)
    c_done |-> (state == ST_LON_WAIT || state == ST_ZC_WAIT || state == ST_FIN_WAIT))
    else $error("CORDIC finished outside a CORDIC wait state");

  // An accepted position closes the input side on the next cycle.
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still open after a transaction");

  // A finished result with a free output register is presented next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free) |=> (m_tvalid && state == ST_IDLE))
    else $error("result not loaded into the output register");

endmodule

@@ bench/ecef_to_geodetic_checker.sv @@
// Checker for the ECEF to geodetic core: watches the ports, predicts each result and compares.
module ecef_to_geodetic_checker #(
  parameter int COORD_BITS = 36,
  parameter int ANGLE_BITS = 32
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_tvalid,
  input  logic                                         s_tready,
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]            s_tdata,
  input  logic                                         m_tvalid,
  input  logic                                         m_tready,
  input  logic [((2*ANGLE_BITS+COORD_BITS+7)/8)*8-1:0] m_tdata,
  input  logic                                         m_tuser,
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [2:0]                                   paddr,
  input  logic [31:0]                                  pwdata,
  input  logic                                         pready,
  output int                                           pending,
  output int                                           fails
);
  import e2g_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ANGLE_BITS-1:0] lat;
    logic [ANGLE_BITS-1:0] lon;
    logic [COORD_BITS-1:0] height;
    logic                  conv;
  } geo_fix_t;

  geo_fix_t     fix_q[$];
  logic [15:0]  tol_um;
  logic [4:0]   iter_lim;
  longint       atan_q46[NSTEP];

  // floor(a * b / 2^s) over the full 128-bit product.
  function automatic longint unsigned mul_shift(longint unsigned a, longint unsigned b, int s);
    logic [127:0] pr;
    pr = {64'd0, a} * {64'd0, b};
    pr = pr >> s;
    return pr[63:0];
  endfunction

  // Vectoring CORDIC for x >= 0; returns the gain-corrected magnitude.
  function automatic longint unsigned cordic_vec(longint x, longint y, output longint ang);
    longint dx;
    longint dy;
    ang = 0;
    for (int i = 0; i < NSTEP; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; ang += atan_q46[i];
      end else begin
        x -= dx; y += dy; ang -= atan_q46[i];
      end
    end
    return mul_shift(longint'(x), INVK_Q32, 32);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // floor(n * 2^30 / d) for n <= d.
  function automatic longint unsigned frac_q30(longint unsigned n, longint unsigned d);
    longint unsigned q;
    q = 0;
    if (n >= d) begin
      q = 1;
      n -= d;
    end
    for (int i = 0; i < 30; i++) begin
      n <<= 1;
      q <<= 1;
      if (n >= d) begin
        n -= d;
        q |= 1;
      end
    end
    return q;
  endfunction

  // Round the internal 2^46 half-turn angle to the output scale, wrapping.
  function automatic logic [ANGLE_BITS-1:0] to_angle(longint a);
    longint unsigned u;
    u = longint'(a) + (64'd1 << (46 - ANGLE_BITS));
    u = u >> (47 - ANGLE_BITS);
    return u[ANGLE_BITS-1:0];
  endfunction

  function automatic geo_fix_t convert_fix(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                                           logic [COORD_BITS-1:0] pz);
    geo_fix_t        r;
    longint          x, y, z0, zc, zk, dz, lon, lat, dum, h, hmax;
    longint unsigned p, v, hyp, adz, az, s, s2, w, rw, rinv, corr;
    int              iter;
    bit              polar, neg;
    x = longint'(signed'(px)) * 1000;
    y = longint'(signed'(py)) * 1000;
    z0 = longint'(signed'(pz)) * 1000;
    polar = (x == 0 && y == 0);
    // Longitude and horizontal distance, folding the left half plane over.
    if (x < 0) begin
      p = cordic_vec(-x, -y, lon);
      lon += longint'(HALF_IN);
    end else begin
      p = cordic_vec(x, y, lon);
    end
    // Refine the corrected z through the prime-vertical radius.
    zc = z0;
    zk = 0;
    v = A_UM;
    iter = 0;
    while (1) begin
      dz = zc - zk;
      adz = dz < 0 ? -dz : dz;
      if (adz < longint'(tol_um)) begin
        r.conv = 1'b1;
        break;
      end
      if (iter >= int'(iter_lim)) begin
        r.conv = 1'b0;
        break;
      end
      zk = zc;
      neg = zc < 0;
      hyp = cordic_vec(longint'(p), zc, dum);
      az = neg ? -zc : zc;
      s = 0;
      if (hyp > 0) s = frac_q30(az < hyp ? az : hyp, hyp);
      s2 = mul_shift(s, s, 30);
      w = ONE_Q30 - mul_shift(E2_Q40, s2, 40);
      rw = int_sqrt(w << 30);
      if (rw == 0) rw = 1;
      rinv = ONE_Q60 / rw;
      v = mul_shift(A_UM, rinv, 30);
      corr = mul_shift(mul_shift(v, E2_Q40, 40), s, 30);
      zc = z0 + (neg ? -longint'(corr) : longint'(corr));
      iter++;
    end
    hyp = cordic_vec(longint'(p), zc, lat);
    // On the polar axis the angles are fixed.
    if (polar) begin
      lat = z0 > 0 ? longint'(QUARTER_IN) : -longint'(QUARTER_IN);
      lon = 0;
    end
    // Height in millimetres, rounded half away from zero and saturated.
    h = longint'(hyp) - longint'(v);
    h = h >= 0 ? (h + 500) / 1000 : -((-h + 500) / 1000);
    hmax = (longint'(1) << (COORD_BITS - 1)) - 1;
    if (h > hmax) h = hmax;
    if (h < -hmax - 1) h = -hmax - 1;
    r.lat = to_angle(lat);
    r.lon = to_angle(lon);
    r.height = h[COORD_BITS-1:0];
    return r;
  endfunction

  // Arctangent table from the alternating series scaled by 1/pi.
  initial begin
    longint sum;
    int     e;
    atan_q46[0] = longint'(QUARTER_IN);
    for (int i = 1; i < NSTEP; i++) begin
      sum = 0;
      for (int k = 0; k < 32; k++) begin
        e = 62 - i * (2 * k + 1);
        if (e >= 0) begin
          if (k % 2 == 1) sum -= longint'((64'd1 << e) / (2 * k + 1));
          else sum += longint'((64'd1 << e) / (2 * k + 1));
        end
      end
      atan_q46[i] = longint'(mul_shift(longint'(sum), INVPI_Q64, 80));
    end
  end

  assign pending = fix_q.size();

  // Track registers, predict on each input transaction, compare each output transaction.
  always @(posedge clk) begin
    geo_fix_t e;
    int       bad;
    bad = 0;
    if (rst) begin
      tol_um <= 16'd100;
      iter_lim <= 5'd10;
      fix_q.delete();
      fails <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ITER_LIMIT) iter_lim <= pwdata[4:0];
        else tol_um <= pwdata[15:0];
      end
      if (s_tvalid && s_tready) begin
        fix_q.push_back(convert_fix(s_tdata[COORD_BITS-1:0], s_tdata[2*COORD_BITS-1:COORD_BITS],
                                    s_tdata[3*COORD_BITS-1:2*COORD_BITS]));
      end
      if (m_tvalid && m_tready) begin
        if (fix_q.size() == 0) begin
          $error("result transaction with no position waiting");
          bad++;
        end else begin
          e = fix_q.pop_front();
          if (m_tdata[ANGLE_BITS-1:0] !== e.lat) begin
            $error("latitude: expected %0d, got %0d", signed'(e.lat),
                   signed'(m_tdata[ANGLE_BITS-1:0]));
            bad++;
          end
          if (m_tdata[2*ANGLE_BITS-1:ANGLE_BITS] !== e.lon) begin
            $error("longitude: expected %0d, got %0d", signed'(e.lon),
                   signed'(m_tdata[2*ANGLE_BITS-1:ANGLE_BITS]));
            bad++;
          end
          if (m_tdata[2*ANGLE_BITS+COORD_BITS-1:2*ANGLE_BITS] !== e.height) begin
            $error("height_mm: expected %0d, got %0d", signed'(e.height),
                   signed'(m_tdata[2*ANGLE_BITS+COORD_BITS-1:2*ANGLE_BITS]));
            bad++;
          end
          if (m_tuser !== e.conv) begin
            $error("converged: expected %0b, got %0b", e.conv, m_tuser);
            bad++;
          end
        end
      end
      if (bad != 0) fails <= fails + bad;
    end
  end

endmodule

@@ bench/tb.sv @@
// Top of the ECEF to geodetic testbench: clock, reset, stimulus and verdict.
module tb;
  import e2g_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 36;
  localparam int AB = 32;
  localparam longint SURFACE_MM = 64'd6400000000;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [((3*CB+7)/8)*8-1:0]      s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [((2*AB+CB+7)/8)*8-1:0]   m_tdata;
  logic                           m_tuser;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [2:0]                     paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;
  int                             pending;
  int                             fails;
  bit                             steady;
  int                             hold_cycles;

  ecef_to_geodetic_core #(.COORD_BITS(CB), .ANGLE_BITS(AB)) i_dut (.*);

  ecef_to_geodetic_checker #(.COORD_BITS(CB), .ANGLE_BITS(AB)) i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit well above the slowest correct run.
  initial begin
    #60_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Result side: random stalls, steady stretches and one long hold-off.
  initial begin
    int held;
    m_tready = 1'b0;
    held = 0;
    forever begin
      @(posedge clk);
      if (held < hold_cycles) begin
        held++;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 32);
      end
    end
  end

  // One register write: setup cycle, then access cycle.
  task automatic reg_write(logic regsel, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regsel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait for every result, then let the block settle before a register write.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Offer one position transaction and hold it until accepted.
  task automatic send_pos(longint x, longint y, longint z);
    if (!steady && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, z[CB-1:0], y[CB-1:0], x[CB-1:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic longint rand_coord(int mode);
    longint r;
    case (mode)
      0: begin
        r = {$urandom, $urandom};
        r = longint'(signed'(r[CB-1:0]));
      end
      1: begin
        r = longint'({$urandom, $urandom} % SURFACE_MM);
        if ($urandom_range(1)) r = -r;
      end
      2: r = longint'($urandom_range(0, 40000)) - 20000;
      default: r = 0;
    endcase
    return r;
  endfunction

  // Mostly positions near the Earth's surface, some anywhere, some tiny or on an axis.
  task automatic send_random(int n);
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(99) < 60 ? 1 : $urandom_range(0, 2);
      send_pos(rand_coord($urandom_range(9) == 0 ? 3 : mode),
               rand_coord($urandom_range(9) == 0 ? 3 : mode),
               rand_coord($urandom_range(19) == 0 ? 3 : mode));
    end
  endtask

  initial begin
    longint cmax;
    longint cmin;
    cmax = (longint'(1) << (CB - 1)) - 1;
    cmin = -(longint'(1) << (CB - 1));
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady = 1'b0;
    hold_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed positions under the reset settings.
    send_pos(0, 0, 0);
    send_pos(0, 0, 6356752314);
    send_pos(0, 0, -6356752314);
    send_pos(0, 0, 1);
    send_pos(6378137000, 0, 0);
    send_pos(-6378137000, 0, 0);
    send_pos(0, 6378137000, 0);
    send_pos(0, -6378137000, 0);
    send_pos(-6378137000, -1, 0);
    send_pos(-6378137000, 1, 1000);
    send_pos(cmax, cmax, cmax);
    send_pos(cmin, cmin, cmin);
    send_pos(cmax, cmin, 0);
    send_pos(cmin, 0, cmax);
    send_pos(1, 0, cmin);
    send_pos(4510731000, 4510731000, 0);
    send_pos(3194419000, 3194419000, 4487348000);
    send_pos(-1, -1, -1);
    send_random(120);

    // Long receiver hold-off while positions keep coming.
    hold_cycles = 4000;
    steady = 1'b1;
    send_random(60);
    steady = 1'b0;
    send_random(120);
    s_tvalid <= 1'b0;
    drain();

    // Smallest nonzero tolerance with a long limit.
    reg_write(REG_TOLERANCE, 32'd1);
    reg_write(REG_ITER_LIMIT, 32'd16);
    send_random(150);
    s_tvalid <= 1'b0;
    drain();

    // Loosest tolerance, single refinement.
    reg_write(REG_TOLERANCE, 32'd65535);
    reg_write(REG_ITER_LIMIT, 32'd1);
    send_random(150);
    s_tvalid <= 1'b0;
    drain();

    // Zero tolerance never converges; largest limit the register holds.
    reg_write(REG_TOLERANCE, 32'd0);
    reg_write(REG_ITER_LIMIT, 32'd31);
    send_random(6);
    s_tvalid <= 1'b0;
    drain();

    // Zero limit: no refinement at all.
    reg_write(REG_TOLERANCE, 32'd5000);
    reg_write(REG_ITER_LIMIT, 32'd0);
    send_pos(0, 0, 4);
    send_pos(0, 0, -5);
    send_random(100);
    s_tvalid <= 1'b0;
    drain();

    // Medium settings with upper bits set in the write data.
    reg_write(REG_TOLERANCE, 32'hFFFF_0200);
    reg_write(REG_ITER_LIMIT, 32'hFFFF_FFE5);
    send_random(100);
    s_tvalid <= 1'b0;
    drain();
    repeat (50) @(posedge clk);

    if (fails == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
